// File: sv/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// shared types, codes and constants of the first-fit range allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int SW          = 17;     // slot number / count width
  localparam int DEF_RANGES  = 64;
  localparam int DEF_SLOTS   = 65536;
  localparam int PROD_W      = 29;     // stride (13) times offset (16)

  localparam logic [2:0] REG_HEAP_KIND   = 3'd0;
  localparam logic [2:0] REG_CAPACITY    = 3'd1;
  localparam logic [2:0] REG_STRIDE      = 3'd2;
  localparam logic [2:0] REG_CPU_BASE    = 3'd3;
  localparam logic [2:0] REG_GPU_BASE    = 3'd4;
  localparam logic [2:0] REG_GPU_VISIBLE = 3'd5;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_UNINIT    = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_INVALID   = 3'd4,
    ST_NULL      = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_PROC,
    ENG_FLUSH,
    ENG_MUL,
    ENG_OUT
  } eng_state_t;

  typedef struct packed {
    logic [SW-1:0] start;
    logic [SW-1:0] len;
  } ent_t;

  typedef struct packed {
    status_t            status;
    logic               grant;
    logic [15:0]        offset;
    logic [PROD_W-1:0]  prod;
    logic [SW-1:0]      total;
  } res_t;

endpackage

// File: sv/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// first-fit slot allocator over a sorted, coalescing list of free ranges
// ----------------------------------------------------------------------------
// request channel: a word is taken when start is high and busy is low
//   (func 0 allocate, 1 free, with slot_count, release_offset, release_kind)
// result channel: done is high for exactly one cycle with status,
//   granted_offset, cpu_handle, gpu_handle and free_total; the receiver
//   takes it in that cycle and cannot hold it off
// configuration: cfg_valid/cfg_ready write channel, cfg_index picks the
//   register, cfg_data carries the word; ready only while idle and no
//   request word is offered
// timing: requests rejected up front (zero count, uninitialised heap, bad
//   free, full list) answer in the cycle after acceptance; otherwise the
//   engine streams once through the N stored ranges, one range a cycle
//   from the range store (one read and one write port) except while the
//   freed range is inserted on a free, then flushes, multiplies and gives
//   the result; a free only runs with fewer than MAX_RANGES ranges stored
// reset: list empty, all configuration registers zero; a capacity write
//   rebuilds the list as one range covering the whole heap (empty for zero)
// one request is in flight at a time; busy drops after the done cycle
// ----------------------------------------------------------------------------
module first_fit_range_allocator #(
  parameter int MAX_RANGES = ffra_pkg::DEF_RANGES
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [16:0] slot_count,
  input  logic [16:0] release_offset,
  input  logic [1:0]  release_kind,
  // result
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] granted_offset,
  output logic [63:0] cpu_handle,
  output logic [63:0] gpu_handle,
  output logic [16:0] free_total,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = $clog2(MAX_RANGES);

  // configuration registers
  logic [1:0]  heap_kind;
  logic [16:0] slot_capacity;
  logic [12:0] slot_stride;
  logic [63:0] cpu_base;
  logic [63:0] gpu_base;
  logic        gpu_visible;

  logic        cfg_wr;
  logic        rebuild;
  logic [16:0] cap_sat;

  ffra_pkg::res_t res;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  ffra_pkg::ent_t mem_wdata, mem_rdata;

  // a request word offered while idle wins over a register write
  assign cfg_ready = !busy && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign rebuild   = cfg_wr && (cfg_index == ffra_pkg::REG_CAPACITY);

  // capacity saturates at DEF_SLOTS (65536 slots)
  assign cap_sat = ({15'd0, cfg_data[16:0]} > 32'(ffra_pkg::DEF_SLOTS)) ?
                   17'(ffra_pkg::DEF_SLOTS) : cfg_data[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_kind     <= '0;
      slot_capacity <= '0;
      slot_stride   <= '0;
      cpu_base      <= '0;
      gpu_base      <= '0;
      gpu_visible   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        ffra_pkg::REG_HEAP_KIND:   heap_kind     <= cfg_data[1:0];
        ffra_pkg::REG_CAPACITY:    slot_capacity <= cap_sat;
        ffra_pkg::REG_STRIDE:      slot_stride   <= cfg_data[12:0];
        ffra_pkg::REG_CPU_BASE:    cpu_base      <= cfg_data;
        ffra_pkg::REG_GPU_BASE:    gpu_base      <= cfg_data;
        ffra_pkg::REG_GPU_VISIBLE: gpu_visible   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ffra_engine #(
    .MAX_RANGES (MAX_RANGES)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .func           (func),
    .slot_count     (slot_count),
    .release_offset (release_offset),
    .release_kind   (release_kind),
    .heap_kind      (heap_kind),
    .capacity       (slot_capacity),
    .stride         (slot_stride),
    .rebuild        (rebuild),
    .rebuild_cap    (cap_sat),
    .busy           (busy),
    .done           (done),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  // free range store
  ffra_mem #(
    .DEPTH (MAX_RANGES)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // handles only for a successful allocate, byte offset from the engine
  assign status         = res.status;
  assign granted_offset = res.grant ? res.offset : '0;
  assign free_total     = res.total;
  assign cpu_handle     = res.grant ? (cpu_base + 64'(res.prod)) : '0;
  assign gpu_handle     = (res.grant && gpu_visible) ? (gpu_base + 64'(res.prod)) : '0;

endmodule

// File: sv/ffra_mem.sv
// ----------------------------------------------------------------------------
// ffra_mem
// free range store, one write and one registered read port
// ----------------------------------------------------------------------------
module ffra_mem #(
  parameter int DEPTH = ffra_pkg::DEF_RANGES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  wr_addr,
  input  ffra_pkg::ent_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output ffra_pkg::ent_t rd_data
);

  ffra_pkg::ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/ffra_engine.sv
// ----------------------------------------------------------------------------
// ffra_engine
// request sequencer: at most one streaming pass over the range store per request
// ----------------------------------------------------------------------------
module ffra_engine #(
  parameter int MAX_RANGES = ffra_pkg::DEF_RANGES,
  parameter int AW         = $clog2(MAX_RANGES),
  parameter int CW         = $clog2(MAX_RANGES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    func,
  input  logic [ffra_pkg::SW-1:0] slot_count,
  input  logic [ffra_pkg::SW-1:0] release_offset,
  input  logic [1:0]              release_kind,
  input  logic [1:0]              heap_kind,
  input  logic [ffra_pkg::SW-1:0] capacity,
  input  logic [12:0]             stride,
  input  logic                    rebuild,
  input  logic [ffra_pkg::SW-1:0] rebuild_cap,
  output logic                    busy,
  output logic                    done,
  output ffra_pkg::res_t          res,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output ffra_pkg::ent_t          mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  ffra_pkg::ent_t          mem_rdata
);

  localparam int SW = ffra_pkg::SW;

  ffra_pkg::eng_state_t state, state_next;

  logic [CW-1:0]   used, used_next;
  logic [SW-1:0]   total, total_next;
  logic [CW-1:0]   r, r_next;
  logic [CW-1:0]   w, w_next;
  logic [SW-1:0]   sum, sum_next;
  logic            q_func;
  logic [SW-1:0]   q_count, q_off;
  logic            inserted, inserted_next;
  logic            found, found_next;
  logic            have_acc, have_acc_next;
  ffra_pkg::ent_t  acc, acc_next;
  ffra_pkg::status_t status, status_next;
  logic [SW-1:0]   goff, goff_next;
  logic [ffra_pkg::PROD_W-1:0] prod;

  // early checks at request time
  ffra_pkg::status_t early_st;
  logic              early;
  logic [CW-1:0]     r_inc;
  logic              take_new;
  ffra_pkg::ent_t    elem;
  logic [SW:0]       acc_end, el_end;
  logic [SW-1:0]     nl;

  assign r_inc = r + 1'b1;

  always_comb begin
    early    = 1'b1;
    early_st = ffra_pkg::ST_OK;
    if (func == ffra_pkg::FUNC_ALLOC) begin
      if (slot_count == '0) begin
        early_st = ffra_pkg::ST_ZERO;
      end else if (capacity == '0 || stride == '0) begin
        early_st = ffra_pkg::ST_UNINIT;
      end else begin
        early = 1'b0;
      end
    end else begin
      if (slot_count == '0) begin
        early_st = ffra_pkg::ST_NULL;
      end else if (release_kind != heap_kind || release_offset > capacity ||
                   slot_count > capacity - release_offset) begin
        early_st = ffra_pkg::ST_INVALID;
      end else if (used >= CW'(MAX_RANGES)) begin
        early_st = ffra_pkg::ST_FULL;
      end else begin
        early = 1'b0;
      end
    end
  end

  // element taken this cycle: the freed range goes in ahead of the first
  // stored range that does not start below it
  assign take_new = (q_func == ffra_pkg::FUNC_FREE) && !inserted &&
                    ((state == ffra_pkg::ENG_FLUSH) || (mem_rdata.start >= q_off));
  assign elem     = take_new ? '{start: q_off, len: q_count} : mem_rdata;
  assign acc_end  = {1'b0, acc.start} + {1'b0, acc.len};
  assign el_end   = {1'b0, elem.start} + {1'b0, elem.len};
  assign nl       = elem.len - q_count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ffra_pkg::ENG_IDLE: begin
        if (start) begin
          if (early) begin
            state_next = ffra_pkg::ENG_OUT;
          end else if (used == '0) begin
            state_next = ffra_pkg::ENG_FLUSH;
          end else begin
            state_next = ffra_pkg::ENG_PROC;
          end
        end
      end
      ffra_pkg::ENG_PROC: begin
        if (!take_new && r_inc >= used) begin
          state_next = ffra_pkg::ENG_FLUSH;
        end
      end
      ffra_pkg::ENG_FLUSH: begin
        if (!take_new) begin
          state_next = ffra_pkg::ENG_MUL;
        end
      end
      ffra_pkg::ENG_MUL: state_next = ffra_pkg::ENG_OUT;
      ffra_pkg::ENG_OUT: state_next = ffra_pkg::ENG_IDLE;
      default:           state_next = ffra_pkg::ENG_IDLE;
    endcase
  end

  // handshake outputs and store reads
  always_comb begin
    busy      = (state != ffra_pkg::ENG_IDLE);
    done      = (state == ffra_pkg::ENG_OUT);
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      ffra_pkg::ENG_IDLE: begin
        mem_re = start && !early && (used != '0);
      end
      ffra_pkg::ENG_PROC: begin
        mem_re    = !take_new && (r_inc < used);
        mem_raddr = r_inc[AW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    used_next     = used;
    total_next    = total;
    r_next        = r;
    w_next        = w;
    sum_next      = sum;
    inserted_next = inserted;
    found_next    = found;
    have_acc_next = have_acc;
    acc_next      = acc;
    status_next   = status;
    goff_next     = goff;
    mem_we        = 1'b0;
    mem_waddr     = w[AW-1:0];
    mem_wdata     = acc;
    case (state)
      ffra_pkg::ENG_IDLE: begin
        if (start) begin
          r_next        = '0;
          w_next        = '0;
          sum_next      = '0;
          inserted_next = 1'b0;
          found_next    = 1'b0;
          have_acc_next = 1'b0;
          goff_next     = '0;
          status_next   = early_st;
        end else if (rebuild) begin
          // list becomes the single range covering the whole heap, or empty for a zero capacity
          used_next  = (rebuild_cap != '0) ? CW'(1) : '0;
          total_next = rebuild_cap;
          mem_we     = 1'b1;
          mem_waddr  = '0;
          mem_wdata  = '{start: '0, len: rebuild_cap};
        end
      end
      ffra_pkg::ENG_PROC, ffra_pkg::ENG_FLUSH: begin
        if (q_func == ffra_pkg::FUNC_FREE) begin
          if (take_new) begin
            inserted_next = 1'b1;
          end else if (state == ffra_pkg::ENG_PROC) begin
            r_next = r_inc;
          end
          if (state == ffra_pkg::ENG_FLUSH && !take_new) begin
            mem_we      = 1'b1;
            used_next   = w + 1'b1;
            total_next  = sum + acc.len;
            status_next = ffra_pkg::ST_OK;
          end else if (!have_acc) begin
            acc_next      = elem;
            have_acc_next = 1'b1;
          end else if ({1'b0, elem.start} <= acc_end) begin
            if (el_end > acc_end) begin
              acc_next.len = SW'(el_end - {1'b0, acc.start});
            end
          end else begin
            mem_we   = 1'b1;
            w_next   = w + 1'b1;
            sum_next = sum + acc.len;
            acc_next = elem;
          end
        end else if (state == ffra_pkg::ENG_PROC) begin
          r_next = r_inc;
          if (!found && elem.len >= q_count) begin
            found_next = 1'b1;
            goff_next  = elem.start;
            if (nl != '0) begin
              mem_we    = 1'b1;
              mem_wdata = '{start: elem.start + q_count, len: nl};
              w_next    = w + 1'b1;
              sum_next  = sum + nl;
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = elem;
            w_next    = w + 1'b1;
            sum_next  = sum + elem.len;
          end
        end else begin
          used_next   = w;
          total_next  = sum;
          status_next = found ? ffra_pkg::ST_OK : ffra_pkg::ST_EXHAUSTED;
          goff_next   = found ? goff : '0;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffra_pkg::ENG_IDLE;
      used     <= '0;
      total    <= '0;
      inserted <= 1'b0;
      found    <= 1'b0;
      have_acc <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      total    <= total_next;
      inserted <= inserted_next;
      found    <= found_next;
      have_acc <= have_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    r      <= r_next;
    w      <= w_next;
    sum    <= sum_next;
    acc    <= acc_next;
    status <= status_next;
    goff   <= goff_next;
    if (state == ffra_pkg::ENG_IDLE && start) begin
      q_func  <= func;
      q_count <= slot_count;
      q_off   <= release_offset;
    end
    if (state == ffra_pkg::ENG_MUL) begin
      // both operands widened to the full product width
      prod <= {16'd0, stride} * {13'd0, goff[15:0]};
    end
  end

  always_comb begin
    res.status = status;
    res.grant  = (q_func == ffra_pkg::FUNC_ALLOC) && (status == ffra_pkg::ST_OK);
    res.offset = goff[15:0];
    res.prod   = prod;
    res.total  = total;
  end

endmodule

// File: sv/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// port-level checks on the allocator's request and result timing, grant fields and configuration window
// ----------------------------------------------------------------------------
module ffra_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [15:0] granted_offset,
  input logic [63:0] cpu_handle,
  input logic [63:0] gpu_handle,
  input logic        cfg_ready
);

  // an accepted word makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // a result only comes from a running request
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // one result per request, then idle
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block still busy after result");

  // failed requests carry no grant
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && status != ffra_pkg::ST_OK |->
      granted_offset == '0 && cpu_handle == '0 && gpu_handle == '0)
    else $error("grant fields set on failed request");

  // configuration only while idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy)
    else $error("configuration open during a request");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .granted_offset (granted_offset),
  .cpu_handle     (cpu_handle),
  .gpu_handle     (gpu_handle),
  .cfg_ready      (cfg_ready)
);
